@@ design/fnvfm_pkg.sv @@
// Shared constants, types and helper functions for the FNV-1a / fmix64 byte hash.
`timescale 1ns / 1ps
package fnvfm_pkg;

  // FNV-1a 64-bit offset basis
  localparam logic [63:0] FnvBasis  = 64'hcbf29ce484222325;
  // fmix64 multiplier constants and shift
  localparam logic [63:0] FmixMulA  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FmixMulB  = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned FmixShift = 33;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDef = 2;

  // queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // multiply by the FNV prime 2^40 + 0x1b3, mod 2^64, as shifts and adds
  function automatic logic [63:0] fnv_mul_prime(input logic [63:0] h);
    return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
  endfunction

  // fmix64 xor-shift step
  function automatic logic [63:0] fmix_xorshift(input logic [63:0] h);
    return h ^ (h >> FmixShift);
  endfunction

endpackage

@@ design/fnvfm_fifo.sv @@
// Small queue carrying absorbed hash words from the front end to the finalizer.
`timescale 1ns / 1ps
module fnvfm_fifo
  import fnvfm_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [63:0] push_data_i,
  input  logic        pop_i,
  output logic [63:0] pop_data_o,
  output fifo_stat_t  stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [63:0]     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/fnvfm_front.sv @@
// Front end: accepts byte words, absorbs them with FNV-1a and queues finished messages.
`timescale 1ns / 1ps
module fnvfm_front
  import fnvfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  input  fifo_stat_t  q_stat_i,
  output logic        q_push_o,
  output logic [63:0] q_data_o
);

  logic [63:0] hash_q, hash_d;
  logic [63:0] absorbed;
  logic        accept;

  // only a word that closes a message needs room in the queue
  assign in_stall_o = q_stat_i.full && last_i;
  assign accept     = in_valid_i && !in_stall_o;

  // absorb this word's byte, if it carries one
  assign absorbed = byte_valid_i ? fnv_mul_prime(hash_q ^ {56'd0, data_byte_i}) : hash_q;

  assign q_push_o = accept && last_i;
  assign q_data_o = absorbed;

  always_comb begin
    hash_d = hash_q;
    if (accept) begin
      hash_d = last_i ? FnvBasis : absorbed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FnvBasis;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

@@ design/fnvfm_back.sv @@
// Back end: fmix64 finalizer on one shared 32x32 multiplier, with the output register.
`timescale 1ns / 1ps
module fnvfm_back
  import fnvfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fifo_stat_t  q_stat_i,
  input  logic [63:0] q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  // sequencer states
  localparam logic StIdle = 1'b0;
  localparam logic StMul  = 1'b1;

  // partial product steps of one 64x64 mod 2^64 multiply
  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepHiLo = 2'd2;

  logic        state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        pass_q, pass_d;
  logic [63:0] x_q, x_d;
  logic [63:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hash_q, out_hash_d;

  logic [63:0] mul_const;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic [63:0] mul_result;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == StIdle) && !q_stat_i.empty;

  // shared multiplier operand selection
  assign mul_const = pass_q ? FmixMulB : FmixMulA;
  always_comb begin
    op_a = x_q[31:0];
    op_b = mul_const[31:0];
    case (step_q)
      StepLoHi: op_b = mul_const[63:32];
      StepHiLo: op_a = x_q[63:32];
      default:  ;
    endcase
  end
  assign prod       = {32'd0, op_a} * {32'd0, op_b};
  assign mul_result = acc_q + {prod[31:0], 32'd0};

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pass_d      = pass_q;
    x_d         = x_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_hash_d  = out_hash_q;
    unique case (state_q)
      StIdle: begin
        if (q_pop_o) begin
          x_d     = fmix_xorshift(q_data_i);
          step_d  = StepLoLo;
          pass_d  = 1'b0;
          state_d = StMul;
        end
      end
      StMul: begin
        unique case (step_q)
          StepLoLo: begin
            acc_d  = prod;
            step_d = StepLoHi;
          end
          StepLoHi: begin
            acc_d  = mul_result;
            step_d = StepHiLo;
          end
          StepHiLo: begin
            if (!pass_q) begin
              x_d    = fmix_xorshift(mul_result);
              pass_d = 1'b1;
              step_d = StepLoLo;
            end else if (out_free) begin
              // final xor-shift into the output register
              out_hash_d  = fmix_xorshift(mul_result);
              out_valid_d = 1'b1;
              state_d     = StIdle;
            end
          end
          default: step_d = StepLoLo;
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= StepLoLo;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    acc_q      <= acc_d;
    out_hash_q <= out_hash_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

@@ design/fnv1a64_fmix_byte_hash.sv @@
// Throughput: one byte word per cycle while in_stall_o is low; the finalizer takes one
//   message at a time, running six passes through one shared 32x32 multiplier after a
//   queue pop, and holds its last step while out_stall_i blocks the output register.
// Messages queue between absorb and finalize, QueueDepth deep.
// Reset: asynchronous, active low; running hash reloads the FNV offset basis, queue and
//   output register are emptied.
`timescale 1ns / 1ps
module fnv1a64_fmix_byte_hash
  import fnvfm_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  fifo_stat_t  q_stat;
  logic        q_push, q_pop;
  logic [63:0] q_wdata, q_rdata;

  // absorb front end
  fnvfm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .q_stat_i     (q_stat),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // message queue
  fnvfm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .stat_o      (q_stat)
  );

  // finalizer back end
  fnvfm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_stat_i     (q_stat),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for the FNV-1a / fmix64 byte hash: random and directed byte streams.
`timescale 1ns / 1ps
module tb;

  // hash constants, kept here so the prediction stands apart from the design
  localparam logic [63:0] OffsetBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime    = 64'h00000100000001b3;
  localparam logic [63:0] MixMulA     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixMulB     = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MixShift    = 33;
  localparam int unsigned PhaseWords  = 360;
  localparam int unsigned DrainCycles = 20;
  localparam longint unsigned CycleLimit = 400000;

  // predicts finished hashes and checks them in order
  class hash_scoreboard;
    logic [63:0] running_hash;
    logic [63:0] pending_hashes[$];
    int unsigned mismatches;

    function new();
      running_hash = OffsetBasis;
      mismatches   = 0;
    endfunction

    // three xor-shifts around two multiplies, all mod 2^64
    function logic [63:0] finalize_mix(logic [63:0] h);
      logic [63:0] m;
      m = h ^ (h >> MixShift);
      m = m * MixMulA;
      m = m ^ (m >> MixShift);
      m = m * MixMulB;
      m = m ^ (m >> MixShift);
      return m;
    endfunction

    // one accepted input word
    function void absorb_word(logic [7:0] b, bit v, bit l);
      if (v) running_hash = (running_hash ^ {56'd0, b}) * FnvPrime;
      if (l) begin
        pending_hashes.push_back(finalize_mix(running_hash));
        running_hash = OffsetBasis;
      end
    endfunction

    // one accepted output word
    function void check_hash(logic [63:0] got);
      logic [63:0] want;
      if (pending_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected hash word %h", got);
        return;
      end
      want = pending_hashes.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("hash_value mismatch: expected %h, got %h", want, got);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        byte_valid_i = 1'b0;
  logic        last_i       = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [63:0] hash_value_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  longint unsigned cycle_count = 0;

  hash_scoreboard hash_model = new();

  fnv1a64_fmix_byte_hash u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("fnv1a64_fmix_byte_hash regression: fail");
      $finish;
    end
  end

  // output side: check accepted words, then pick next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) hash_model.check_hash(hash_value_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // present one word after a random gap, return at the edge that takes it
  task automatic send_word(logic [7:0] b, bit v, bit l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    byte_valid_i <= v;
    last_i       <= l;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hash_model.absorb_word(b, v, l);
    words_sent++;
  endtask

  // random message: mostly short, now and then long, with ignored words mixed in
  task automatic send_random_message();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(48) : $urandom_range(10);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_word(8'($urandom_range(255)), 1'b0, 1'b0);
      send_word(8'($urandom_range(255)), 1'b1, 1'b0);
    end
    send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  // hold the input off until every hash is out
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hash_model.pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    int unsigned target;
    target         = words_sent + PhaseWords;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (words_sent < target) send_random_message();
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, byte extremes, ignored words, last without a byte
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'h5a, 1'b0, 1'b0);
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h33, 1'b0, 1'b1);
    send_word(8'ha5, 1'b1, 1'b0);
    send_word(8'h5a, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hff, 1'b0, 1'b1);
    send_word(8'h7f, 1'b1, 1'b1);
    wait_for_drain();

    run_phase(0, 0);
    run_phase(63, 0);
    run_phase(0, 63);
    run_phase(12, 12);

    // let any stray output show up
    repeat (DrainCycles) @(posedge clk_i);
    if (hash_model.mismatches == 0 && hash_model.pending_hashes.size() == 0) begin
      $display("fnv1a64_fmix_byte_hash regression: pass");
    end else begin
      $display("fnv1a64_fmix_byte_hash regression: fail");
    end
    $finish;
  end

endmodule
